// ===== hdl/raycast_wall_column_shader_defines.svh =====
// Assertion helpers shared by the shader RTL.
`ifndef RAYCAST_WALL_COLUMN_SHADER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_SHADER_DEFINES_SVH

// Condition must hold on every clock outside reset.
`define RWCS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define RWCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/rwcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcs_pkg
// Constants, widths and types of the raycast wall column shader.
// ----------------------------------------------------------------------------
package rwcs_pkg;

   localparam int TEX_DIM    = 64;
   localparam int TILE_UNITS = 64;
   localparam int MAX_ROWS   = 1024;

   localparam int TEX_BITS   = $clog2(TEX_DIM);
   localparam int TILE_BITS  = $clog2(TILE_UNITS);
   localparam int TEX_AREA   = TEX_DIM * TEX_DIM;
   localparam int ADDR_W     = 2 + 2 * TEX_BITS;
   localparam int TEX_DEPTH  = 4 * TEX_AREA;
   localparam int RGB_W      = 24;

   // divider: numerator is proj_plane_dist << (TILE_BITS + 8)
   localparam int NUM_W      = 24 + TILE_BITS + 8;
   localparam int REM_W      = 32;
   localparam int CNT_W      = $clog2(NUM_W + 1);

   localparam logic [1:0] REQ_TEXEL  = 2'd0;
   localparam logic [1:0] REQ_COLUMN = 2'd1;
   localparam logic [1:0] REQ_PIXEL  = 2'd2;

   localparam logic [1:0] CSR_ROWS  = 2'd0;
   localparam logic [1:0] CSR_CEIL  = 2'd1;
   localparam logic [1:0] CSR_FLOOR = 2'd2;
   localparam logic [1:0] CSR_PPD   = 2'd3;

   localparam logic [1:0] REG_CEIL  = 2'd0;
   localparam logic [1:0] REG_WALL  = 2'd1;
   localparam logic [1:0] REG_FLOOR = 2'd2;
   localparam logic [1:0] REG_OUT   = 2'd3;

   localparam logic [2:0] FACE_NONE = 3'd4;

   typedef struct packed {
      logic                 start;
      logic [REM_W-1:0]     rem;
      logic [NUM_W-1:0]     bits;
      logic [CNT_W-1:0]     steps;
      logic [REM_W-1:0]     den;
   } div_req_type;

endpackage

// ===== hdl/rwcs_tex_ram.sv =====
// ----------------------------------------------------------------------------
// rwcs_tex_ram
// Texture store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rwcs_tex_ram (
   input  logic                        clock,
   input  logic                        we,
   input  logic [rwcs_pkg::ADDR_W-1:0] waddr,
   input  logic [rwcs_pkg::RGB_W-1:0]  wdata,
   input  logic                        re,
   input  logic [rwcs_pkg::ADDR_W-1:0] raddr,
   output logic [rwcs_pkg::RGB_W-1:0]  rdata
);

   logic [rwcs_pkg::RGB_W-1:0] mem [rwcs_pkg::TEX_DEPTH];
   logic [rwcs_pkg::RGB_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/rwcs_divider.sv =====
// ----------------------------------------------------------------------------
// rwcs_divider
// Restoring divider, one quotient bit per cycle, variable step count.
// ----------------------------------------------------------------------------
module rwcs_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  rwcs_pkg::div_req_type      req,
   output logic                       busy,
   output logic                       done,
   output logic [rwcs_pkg::NUM_W-1:0] quot
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [rwcs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [rwcs_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [rwcs_pkg::NUM_W-1:0] q_ff, q_in;
   logic [rwcs_pkg::REM_W-1:0] den_ff, den_in;
   logic [rwcs_pkg::REM_W:0]   trial;
   logic                       fits;

   // numerator bits leave at the top of q, quotient bits enter at the bottom
   assign trial = {rem_ff, q_ff[rwcs_pkg::NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.steps;
         rem_in  = req.rem;
         q_in    = req.bits;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = fits ? rwcs_pkg::REM_W'(trial - {1'b0, den_ff})
                       : trial[rwcs_pkg::REM_W-1:0];
         q_in   = {q_ff[rwcs_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff - rwcs_pkg::CNT_W'(1);
         if (cnt_ff == rwcs_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== hdl/raycast_wall_column_shader.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_column_shader
// Shades one raycaster screen column from four textures held in a RAM.
// ----------------------------------------------------------------------------
// One item at a time. A texel load is written to the RAM as it is accepted.
// A column start runs a 38-step bit-serial division of the projected height.
// A pixel row outside the wall, or on a faceless wall, is classified and goes
// straight to the output; a textured wall pixel runs a 7-step division for
// the texture row and then the registered texture RAM read. The result sits
// in an output register, so the next item is taken while it waits to be drained.
module raycast_wall_column_shader (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // texture_sel[1:0] texel_index[13:2] texel_rgb[37:14] wall_dist[61:38]
   // view_cos[77:62] hit_face[80:78] hit_coord[96:81] pixel_row[106:97]
   input  logic [111:0]  req_tdata,
   input  logic [1:0]    req_tuser,   // req_type[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,   // pixel_color[23:0]
   output logic [1:0]    rsp_tuser,   // region[1:0]
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [23:0]   csr_wdata
);

`include "raycast_wall_column_shader_defines.svh"

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_COL_MUL   = 4'd1;
   localparam logic [3:0] ST_COL_START = 4'd2;
   localparam logic [3:0] ST_COL_DIV   = 4'd3;
   localparam logic [3:0] ST_PIX_CLASS = 4'd4;
   localparam logic [3:0] ST_PIX_DIV   = 4'd5;
   localparam logic [3:0] ST_PIX_RD    = 4'd6;
   localparam logic [3:0] ST_PIX_OUT   = 4'd7;

   localparam int TB = rwcs_pkg::TEX_BITS;

   // request fields
   logic [1:0]  f_sel;
   logic [11:0] f_idx;
   logic [23:0] f_rgb, f_dist;
   logic [15:0] f_cos, f_coord;
   logic [2:0]  f_face;
   logic [9:0]  f_row;
   assign f_sel   = req_tdata[1:0];
   assign f_idx   = req_tdata[13:2];
   assign f_rgb   = req_tdata[37:14];
   assign f_dist  = req_tdata[61:38];
   assign f_cos   = req_tdata[77:62];
   assign f_face  = req_tdata[80:78];
   assign f_coord = req_tdata[96:81];
   assign f_row   = req_tdata[106:97];

   logic [3:0]  state_ff, state_in;
   logic [10:0] rows_ff;
   logic [23:0] ceil_ff, floor_ff, ppd_ff;
   logic [23:0] dist_ff, dist_in;
   logic [15:0] cos_ff, cos_in;
   logic [2:0]  face_req_ff, face_req_in;
   logic [TB-1:0] col_req_ff, col_req_in;
   logic [9:0]  row_ff, row_in;
   logic [24:0] corr_ff, corr_in;
   logic signed [31:0] top_ff, top_in;
   logic [31:0] span_ff, span_in;
   logic [TB-1:0] tex_col_ff, tex_col_in;
   logic [2:0]  face_ff, face_in;
   logic [23:0] color_ff, color_in;
   logic [1:0]  region_ff, region_in;
   logic        use_ram_ff, use_ram_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic        accept;
   logic [39:0] prod;
   logic [10:0] rows_eff;
   logic [17:0] center8, y8;
   logic [36:0] half_raw;
   logic [29:0] half;
   logic signed [33:0] y8_s, top_s, bot_s, diff;
   logic [6:0]  trow_raw;
   logic [TB-1:0] trow;
   logic        slot_free;

   rwcs_pkg::div_req_type         div_req;
   logic                          div_busy, div_done;
   logic [rwcs_pkg::NUM_W-1:0]    div_quot;
   logic                          ram_we, ram_re;
   logic [rwcs_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [23:0]                   ram_q;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid & req_tready;
   assign slot_free  = ~rsp_valid_ff | rsp_tready;

   assign prod     = 40'(dist_ff) * 40'(cos_ff);
   assign rows_eff = (rows_ff > 11'(rwcs_pkg::MAX_ROWS)) ? 11'(rwcs_pkg::MAX_ROWS) : rows_ff;
   assign center8  = {rows_eff[10:1], 8'd0};
   assign half_raw = div_quot[rwcs_pkg::NUM_W-1:1];
   assign half     = (half_raw > 37'h2000_0000) ? 30'h2000_0000 : half_raw[29:0];
   assign y8       = {row_ff, 8'd0};
   assign y8_s     = $signed({16'd0, y8});
   assign top_s    = 34'(top_ff);
   assign bot_s    = top_s + $signed({2'b00, span_ff});
   assign diff     = y8_s - top_s;
   assign trow_raw = div_quot[6:0];
   assign trow     = (trow_raw > 7'(rwcs_pkg::TEX_DIM - 1)) ? TB'(rwcs_pkg::TEX_DIM - 1)
                                                           : trow_raw[TB-1:0];

   assign ram_we    = accept && req_tuser == rwcs_pkg::REQ_TEXEL
                      && {20'd0, f_idx} < 32'(rwcs_pkg::TEX_AREA);
   assign ram_waddr = {f_sel, f_idx[2*TB-1:0]};
   assign ram_re    = state_ff == ST_PIX_DIV && div_done;
   assign ram_raddr = {face_ff[1:0], trow, tex_col_ff};

   always_comb begin
      state_in     = state_ff;
      dist_in      = dist_ff;
      cos_in       = cos_ff;
      face_req_in  = face_req_ff;
      col_req_in   = col_req_ff;
      row_in       = row_ff;
      corr_in      = corr_ff;
      top_in       = top_ff;
      span_in      = span_ff;
      tex_col_in   = tex_col_ff;
      face_in      = face_ff;
      color_in     = color_ff;
      region_in    = region_ff;
      use_ram_in   = use_ram_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dist_in     = f_dist;
               cos_in      = f_cos;
               face_req_in = f_face;
               col_req_in  = f_coord[TB-1:0];
               row_in      = f_row;
               case (req_tuser)
                  rwcs_pkg::REQ_COLUMN: state_in = ST_COL_MUL;
                  rwcs_pkg::REQ_PIXEL:  state_in = ST_PIX_CLASS;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_COL_MUL: begin
            corr_in  = prod[39:15];
            state_in = ST_COL_START;
         end
         ST_COL_START: begin
            div_req.start = 1'b1;
            div_req.rem   = '0;
            div_req.bits  = {ppd_ff, (rwcs_pkg::TILE_BITS + 8)'(0)};
            div_req.steps = rwcs_pkg::CNT_W'(rwcs_pkg::NUM_W);
            div_req.den   = (corr_ff == '0) ? 32'd1 : {7'd0, corr_ff};
            state_in      = ST_COL_DIV;
         end
         ST_COL_DIV: begin
            if (div_done) begin
               top_in     = $signed({14'd0, center8}) - $signed({2'b00, half});
               span_in    = {1'b0, half, 1'b0};
               tex_col_in = col_req_ff;
               face_in    = (face_req_ff <= 3'd3) ? face_req_ff : rwcs_pkg::FACE_NONE;
               state_in   = ST_IDLE;
            end
         end
         ST_PIX_CLASS: begin
            use_ram_in = 1'b0;
            state_in   = ST_PIX_OUT;
            if ({1'b0, row_ff} >= rows_eff) begin
               region_in = rwcs_pkg::REG_OUT;
               color_in  = '0;
            end else if (y8_s <= top_s) begin
               region_in = rwcs_pkg::REG_CEIL;
               color_in  = ceil_ff;
            end else if (y8_s <= bot_s) begin
               region_in = rwcs_pkg::REG_WALL;
               color_in  = '0;
               if (face_ff != rwcs_pkg::FACE_NONE && span_ff != '0) begin
                  // num = diff*TEX_DIM; quotient < 2^7, so preload num >> 7
                  div_req.start = 1'b1;
                  div_req.rem   = 32'(diff[31:0] >> (7 - TB));
                  div_req.bits  = {diff[6-TB:0], TB'(0), (rwcs_pkg::NUM_W - 7)'(0)};
                  div_req.steps = rwcs_pkg::CNT_W'(7);
                  div_req.den   = span_ff;
                  use_ram_in    = 1'b1;
                  state_in      = ST_PIX_DIV;
               end
            end else begin
               region_in = rwcs_pkg::REG_FLOOR;
               color_in  = floor_ff;
            end
         end
         ST_PIX_DIV: begin
            if (div_done) begin
               state_in = ST_PIX_RD;
            end
         end
         ST_PIX_RD: begin
            state_in = ST_PIX_OUT;
         end
         ST_PIX_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = use_ram_ff ? ram_q : color_ff;
               rsp_user_in  = region_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 11'd480;
         ceil_ff      <= '0;
         floor_ff     <= '0;
         ppd_ff       <= 24'd141312;
         top_ff       <= '0;
         span_ff      <= '0;
         tex_col_ff   <= '0;
         face_ff      <= rwcs_pkg::FACE_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         span_ff      <= span_in;
         tex_col_ff   <= tex_col_in;
         face_ff      <= face_in;
         if (csr_we) begin
            case (csr_index)
               rwcs_pkg::CSR_ROWS:  rows_ff  <= csr_wdata[10:0];
               rwcs_pkg::CSR_CEIL:  ceil_ff  <= csr_wdata;
               rwcs_pkg::CSR_FLOOR: floor_ff <= csr_wdata;
               rwcs_pkg::CSR_PPD:   ppd_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
      dist_ff     <= dist_in;
      cos_ff      <= cos_in;
      face_req_ff <= face_req_in;
      col_req_ff  <= col_req_in;
      row_ff      <= row_in;
      corr_ff     <= corr_in;
      color_ff    <= color_in;
      region_ff   <= region_in;
      use_ram_ff  <= use_ram_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   rwcs_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   rwcs_tex_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (f_rgb),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `RWCS_ASSERT_IMPL(a_div_owner, clock, reset, div_busy,
      state_ff == ST_COL_DIV || state_ff == ST_PIX_DIV)
   `RWCS_ASSERT_IMPL(a_ready_div_idle, clock, reset, req_tready, !div_busy)
   `RWCS_ASSERT_ALWAYS(a_face_code, clock, reset, face_ff <= rwcs_pkg::FACE_NONE)
   `RWCS_ASSERT_IMPL(a_ram_wall, clock, reset, ram_re, region_ff == rwcs_pkg::REG_WALL)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for raycast_wall_column_shader. A directed table probes
// the reset state, the distance and cosine extremes, faceless columns and
// out-of-screen rows. Random column/pixel sequences follow over several
// register settings. A local predictor tracks the textures, the column state
// and the registers, and every output beat is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
   import rwcs_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE      = 60;
   localparam int PHASE_ITEMS = 245;
   localparam int N_DIRECTED  = 20;

   // request type with no meaning; the block drops it
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  sel;
      logic [11:0] idx;
      logic [23:0] rgb;
      logic [23:0] wdist;
      logic [15:0] vcos;
      logic [2:0]  face;
      logic [15:0] coord;
      logic [9:0]  row;
      bit          has_exp;
      logic [23:0] color;
      logic [1:0]  region;
   } req_item_t;

   typedef struct {
      logic [23:0] color;
      logic [1:0]  region;
   } pixel_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [23:0]  csr_wdata = '0;

   raycast_wall_column_shader uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [23:0]     tex_mem [TEX_DEPTH];
   bit              tex_written [TEX_DEPTH];
   longint          col_top;
   longint          col_span;
   int              col_tex_x;
   int              col_face;
   logic [10:0]     rows_reg;
   logic [23:0]     ceil_reg;
   logic [23:0]     floor_reg;
   logic [23:0]     ppd_reg;

   pixel_t          pixel_q [$];
   int              errors = 0;
   int              cycles = 0;
   int              n_items = 0;
   bit              no_gaps = 0;
   int              stall_left = 0;
   int              stall_pct = 20;
   req_item_t       directed [N_DIRECTED];

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int rows_eff();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
   endfunction

   function automatic void column_setup(input req_item_t it);
      longint unsigned corr, h8, half;
      corr = (longint'(it.wdist) * longint'(it.vcos)) >> 15;
      if (corr == 0) corr = 1;
      h8 = ((longint'(TILE_UNITS) * longint'(ppd_reg)) << 8) / corr;
      half = h8 >> 1;
      if (half > (64'd1 << 29)) half = 64'd1 << 29;
      col_top = longint'(rows_eff() / 2) * 256 - longint'(half);
      col_span = 2 * longint'(half);
      col_tex_x = it.coord % TEX_DIM;
      col_face = (it.face < FACE_NONE) ? int'(it.face) : int'(FACE_NONE);
   endfunction

   // true when the row lands on a textured wall; addr is the texel read
   function automatic bit wall_texel(input logic [9:0] row, output int addr);
      longint y8, r;
      y8 = longint'(row) * 256;
      addr = 0;
      if (row >= rows_eff() || y8 <= col_top || y8 > col_top + col_span) return 0;
      if (col_face >= int'(FACE_NONE) || col_span <= 0) return 0;
      r = ((y8 - col_top) * TEX_DIM) / col_span;
      if (r > TEX_DIM - 1) r = TEX_DIM - 1;
      addr = col_face * TEX_AREA + int'(r) * TEX_DIM + col_tex_x;
      return 1;
   endfunction

   function automatic pixel_t shade_pixel(input logic [9:0] row);
      pixel_t p;
      int     addr;
      longint y8;
      y8 = longint'(row) * 256;
      p.color = '0;
      if (row >= rows_eff()) p.region = REG_OUT;
      else if (y8 <= col_top) begin
         p.region = REG_CEIL;
         p.color = ceil_reg;
      end else if (y8 <= col_top + col_span) begin
         p.region = REG_WALL;
         if (wall_texel(row, addr)) p.color = tex_mem[addr];
      end else begin
         p.region = REG_FLOOR;
         p.color = floor_reg;
      end
      return p;
   endfunction

   function automatic req_item_t rand_item();
      req_item_t it;
      it.kind = REQ_PIXEL;
      it.sel = 2'($urandom);
      it.idx = 12'($urandom);
      it.rgb = 24'($urandom);
      it.wdist = 24'($urandom_range(1, 24'hFFFFFF));
      it.vcos = 16'($urandom_range(1, 32768));
      it.face = 3'($urandom_range(0, 4));
      it.coord = 16'($urandom);
      it.row = 10'($urandom);
      it.has_exp = 0;
      it.color = '0;
      it.region = '0;
      return it;
   endfunction

   task automatic push_beat(input req_item_t it);
      int g;
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {5'd0, it.row, it.coord, it.face, it.vcos, it.wdist, it.rgb, it.idx, it.sel};
      do @(posedge clock); while (!req_tready);
      case (it.kind)
         REQ_TEXEL: begin
            tex_mem[{it.sel, it.idx}] = it.rgb;
            tex_written[{it.sel, it.idx}] = 1;
         end
         REQ_COLUMN: column_setup(it);
         REQ_PIXEL: begin
            if (it.has_exp) pixel_q.push_back('{it.color, it.region});
            else pixel_q.push_back(shade_pixel(it.row));
         end
         default: ;
      endcase
      n_items++;
      g = no_gaps ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // a wall texel that was never loaded gets loaded first
   task automatic send_req(input req_item_t it);
      req_item_t ld;
      int        addr;
      if (it.kind == REQ_PIXEL && wall_texel(it.row, addr) && !tex_written[addr]) begin
         ld = rand_item();
         ld.kind = REQ_TEXEL;
         ld.sel = addr[13:12];
         ld.idx = addr[11:0];
         push_beat(ld);
      end
      push_beat(it);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ROWS:  rows_reg = val[10:0];
         CSR_CEIL:  ceil_reg = val;
         CSR_FLOOR: floor_reg = val;
         CSR_PPD:   ppd_reg = val;
         default: ;
      endcase
   endtask

   task automatic set_regs(input logic [23:0] rows, input logic [23:0] ceil_c,
                           input logic [23:0] floor_c, input logic [23:0] ppd);
      csr_write(CSR_ROWS, rows);
      csr_write(CSR_CEIL, ceil_c);
      csr_write(CSR_FLOOR, floor_c);
      csr_write(CSR_PPD, ppd);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int target);
      req_item_t it;
      int        p, q, k, stop;
      stop = n_items + target;
      while (n_items < stop) begin
         if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
         p = $urandom_range(0, 99);
         if (p < 70) begin
            it = rand_item();
            it.kind = REQ_COLUMN;
            q = $urandom_range(0, 9);
            if (q < 7) it.wdist = 24'($urandom_range(512, 1 << 19));
            else if (q == 9) it.wdist = 24'($urandom_range(1, 300));
            if ($urandom_range(0, 9) == 0) it.vcos = 16'd32768;
            if ($urandom_range(0, 5) == 0) it.face = 3'($urandom_range(4, 7));
            else it.face = 3'($urandom_range(0, 3));
            send_req(it);
            k = $urandom_range(1, 12);
            repeat (k) begin
               it = rand_item();
               if ($urandom_range(0, 4) != 0) it.row = 10'($urandom_range(0, rows_eff() - 1));
               send_req(it);
            end
         end else if (p < 85) begin
            k = $urandom_range(1, 4);
            repeat (k) begin
               it = rand_item();
               it.kind = REQ_TEXEL;
               send_req(it);
            end
         end else begin
            it = rand_item();
            if ($urandom_range(0, 1) == 0) it.kind = REQ_UNKNOWN;
            send_req(it);
         end
      end
   endtask

   // output checker
   always @(posedge clock) begin
      pixel_t exp_px;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: color %h region %0d", rsp_tdata, rsp_tuser);
         end else begin
            exp_px = pixel_q.pop_front();
            if (rsp_tdata !== exp_px.color || rsp_tuser !== exp_px.region) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected color %h region %0d, got color %h region %0d",
                           exp_px.color, exp_px.region, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // output back-pressure, with stretches of none
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= gap_len();
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= 1'b1;
      if ($urandom_range(0, 299) == 0)
         stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      // kind sel idx rgb wdist vcos face coord row has_exp color region
      directed = '{
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd0, 1, 24'h0, REG_CEIL},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd479, 1, 24'h0, REG_FLOOR},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd480, 1, 24'h0, REG_OUT},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd1023, 1, 24'h0, REG_OUT},
         '{REQ_UNKNOWN, 2'd3, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 10'h3FF,
           0, 24'h0, 2'd0},
         '{REQ_TEXEL, 2'd0, 12'd0, 24'hFFFFFF, 24'd1, 16'd1, 3'd0, 16'd0, 10'd0, 0, 24'h0, 2'd0},
         '{REQ_TEXEL, 2'd3, 12'hFFF, 24'h000000, 24'd1, 16'd1, 3'd0, 16'd0, 10'd0, 0, 24'h0, 2'd0},
         // zero corrected distance: saturated wall covers the screen
         '{REQ_COLUMN, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'hFFFF, 10'd0, 0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd0, 0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd479, 0, 24'h0, 2'd0},
         '{REQ_COLUMN, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd7, 16'd5, 10'd0, 0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd100, 1, 24'h0, REG_WALL},
         // farthest wall: a thin band around row 240
         '{REQ_COLUMN, 2'd0, 12'd0, 24'h0, 24'hFFFFFF, 16'd32768, 3'd3, 16'd0, 10'd0,
           0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd239, 1, 24'h0, REG_CEIL},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd240, 0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd241, 1, 24'h0, REG_FLOOR},
         '{REQ_COLUMN, 2'd0, 12'd0, 24'h0, 24'd16384, 16'd32768, 3'd4, 16'd63, 10'd0,
           0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd240, 1, 24'h0, REG_WALL},
         '{REQ_COLUMN, 2'd0, 12'd0, 24'h0, 24'd16384, 16'd23170, 3'd1, 16'd64, 10'd0,
           0, 24'h0, 2'd0},
         '{REQ_PIXEL, 2'd0, 12'd0, 24'h0, 24'd1, 16'd1, 3'd0, 16'd0, 10'd400, 0, 24'h0, 2'd0}
      };
      rows_reg = 11'd480;
      ceil_reg = '0;
      floor_reg = '0;
      ppd_reg = 24'd141312;
      col_top = 0;
      col_span = 0;
      col_tex_x = 0;
      col_face = FACE_NONE;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_req(directed[i]);
      drain();

      set_regs(24'd480, 24'h202020, 24'h808080, 24'd141312);
      random_phase(PHASE_ITEMS);
      drain();
      set_regs(24'd1, 24'hFFFFFF, 24'h000000, 24'd1);
      random_phase(PHASE_ITEMS);
      drain();
      set_regs(24'd1024, 24'($urandom), 24'($urandom), 24'hFFFFFF);
      random_phase(PHASE_ITEMS);
      drain();
      set_regs(24'd2047, 24'($urandom), 24'($urandom), 24'd141312);   // rows clamp to the maximum
      random_phase(PHASE_ITEMS);
      drain();
      set_regs(24'd200, 24'($urandom), 24'($urandom), 24'd4096);
      random_phase(PHASE_ITEMS);
      drain();
      set_regs(24'($urandom_range(1, 1024)), 24'($urandom), 24'($urandom),
               24'($urandom_range(1, 24'hFFFFFF)));
      random_phase(PHASE_ITEMS);
      drain();

      if (errors == 0 && pixel_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
